>>> hdl/cc20_pkg.sv
`timescale 1ns / 1ps
package cc20_pkg;

  localparam int ROUND_COUNT_DEF = 20;
  localparam int CFG_NUM = 8;
  localparam int CFG_IDX_W = 3;

  // register index that also reloads the running block counter
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER = 3'd6;

  localparam logic [3:0] CHUNK_MAX = 4'd8;
  localparam logic [6:0] BLOCK_BYTES = 7'd64;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] blk_t;

  typedef struct packed {
    logic [63:0] msg;
    logic [3:0]  cnt;
    logic        last;
  } chunk_t;

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic blk_t qr(blk_t w, int a, int b, int c, int d);
    blk_t x;
    x = w;
    x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 16);
    x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 12);
    x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 8);
    x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 7);
    return x;
  endfunction

  // column round followed by diagonal round
  function automatic blk_t double_round(blk_t w);
    blk_t x;
    x = w;
    x = qr(x, 0, 4, 8, 12);
    x = qr(x, 1, 5, 9, 13);
    x = qr(x, 2, 6, 10, 14);
    x = qr(x, 3, 7, 11, 15);
    x = qr(x, 0, 5, 10, 15);
    x = qr(x, 1, 6, 11, 12);
    x = qr(x, 2, 7, 8, 13);
    x = qr(x, 3, 4, 9, 14);
    return x;
  endfunction

  // low k bytes set, k in 0..8
  function automatic logic [63:0] byte_mask(logic [3:0] k);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < k) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

>>> hdl/cc20_ifs.sv
`timescale 1ns / 1ps
interface cc20_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_chunk;
  logic [3:0]  chunk_bytes;
  logic        chunk_last;
  modport source(output valid, message_chunk, chunk_bytes, chunk_last, input ready);
  modport sink(input valid, message_chunk, chunk_bytes, chunk_last, output ready);
endinterface

interface cc20_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_chunk;
  logic [3:0]  result_bytes;
  logic        result_last;
  modport source(output valid, result_chunk, result_bytes, result_last, input ready);
  modport sink(input valid, result_chunk, result_bytes, result_last, output ready);
endinterface

interface cc20_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  wr_index;
  logic [63:0] wr_data;
  modport source(output valid, wr_index, wr_data, input ready);
  modport sink(input valid, wr_index, wr_data, output ready);
endinterface

>>> hdl/cc20_front.sv
`timescale 1ns / 1ps
module cc20_front import cc20_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  cc20_in_if.sink in_ch,
  output logic    head_valid,
  output chunk_t  head,
  input  logic    head_pop
);

  localparam int QDEPTH = 2;

  chunk_t     q_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  chunk_t     in_item;
  logic       push, pop;

  // clamp oversized byte counts on the way in
  always_comb begin
    in_item.msg  = in_ch.message_chunk;
    in_item.cnt  = (in_ch.chunk_bytes > CHUNK_MAX) ? CHUNK_MAX : in_ch.chunk_bytes;
    in_item.last = in_ch.chunk_last;
  end

  assign in_ch.ready = (fill_r != 2'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (fill_r != 2'd0);
  assign head        = q_r[rd_ptr_r];
  assign pop         = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + 2'd1;
      2'b01:   fill_nxt = fill_r - 2'd1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= in_item;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 2'(QDEPTH)) else $error("queue fill out of range");

endmodule

>>> hdl/cc20_core.sv
`timescale 1ns / 1ps
module cc20_core import cc20_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  blk_t init,
  output logic done,
  output blk_t block
);

  localparam int DR = (ROUND_COUNT + 1) / 2;
  localparam int CW = $clog2(DR + 1);

  blk_t          w_r, init_r;
  logic [CW-1:0] left_r;
  logic          busy_r;

  assign done = busy_r && (left_r == '0);

  // feed-forward add of the input state
  always_comb begin
    for (int i = 0; i < 16; i++) block[i] = w_r[i] + init_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      left_r <= CW'(DR);
    end else if (busy_r && left_r != '0) begin
      left_r <= left_r - 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w_r    <= init;
      init_r <= init;
    end else if (busy_r && left_r != '0) begin
      w_r <= double_round(w_r);
    end
  end

endmodule

>>> hdl/cc20_back.sv
`timescale 1ns / 1ps
module cc20_back import cc20_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         head_valid,
  input  chunk_t       head,
  output logic         head_pop,
  output logic         core_start,
  output blk_t         core_init,
  input  logic         core_done,
  input  blk_t         core_block,
  cc20_out_if.source   out_ch,
  cc20_cfg_if.sink     cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MIX  = 4'b0010,
    S_GEN  = 4'b0100,
    S_SEND = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CFG_NUM-1:0][63:0]  cfg_r, cfg_nxt;
  logic [63:0]               ctr_r, ctr_nxt;
  logic [511:0]              ks_r, ks_nxt;
  logic [6:0]                pos_r, pos_nxt;
  logic                      rdy_r, rdy_nxt;
  chunk_t                    item_r, item_nxt;
  logic [3:0]                done_r, done_nxt;
  logic [63:0]               res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [63:0]               out_chunk_r, out_chunk_nxt;
  logic [3:0]                out_bytes_r, out_bytes_nxt;
  logic                      out_last_r, out_last_nxt;

  logic [6:0]  avail;
  logic [3:0]  rem, take;
  logic        need_blk, finish, out_free;
  logic [63:0] mask, merged;

  assign core_init = blk_t'({cfg_r[7], ctr_r, cfg_r[5:0]});

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_chunk = out_chunk_r;
  assign out_ch.result_bytes = out_bytes_r;
  assign out_ch.result_last  = out_last_r;
  assign cfg_ch.ready        = 1'b1;

  always_comb begin
    avail    = BLOCK_BYTES - pos_r;
    rem      = item_r.cnt - done_r;
    need_blk = (rem != 4'd0) && (!rdy_r || pos_r == BLOCK_BYTES);
    if (need_blk)                 take = 4'd0;
    else if (avail < {3'b0, rem}) take = avail[3:0];
    else                          take = rem;
    mask     = byte_mask(done_r + take) & ~byte_mask(done_r);
    // keystream bytes line up with the message bytes still to do
    merged   = res_r | ((item_r.msg ^ (ks_r[63:0] << {done_r[2:0], 3'b000})) & mask);
    finish   = !need_blk && (take == rem);
    out_free = !out_valid_r || out_ch.ready;
  end

  always_comb begin
    state_nxt     = state_r;
    cfg_nxt       = cfg_r;
    ctr_nxt       = ctr_r;
    ks_nxt        = ks_r;
    pos_nxt       = pos_r;
    rdy_nxt       = rdy_r;
    item_nxt      = item_r;
    done_nxt      = done_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_chunk_nxt = out_chunk_r;
    out_bytes_nxt = out_bytes_r;
    out_last_nxt  = out_last_r;
    head_pop      = 1'b0;
    core_start    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          head_pop  = 1'b1;
          item_nxt  = head;
          done_nxt  = 4'd0;
          res_nxt   = '0;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        if (need_blk) begin
          core_start = 1'b1;
          state_nxt  = S_GEN;
        end else begin
          done_nxt = done_r + take;
          pos_nxt  = pos_r + {3'b0, take};
          ks_nxt   = ks_r >> {take, 3'b000};
          res_nxt  = merged;
          if (finish) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_chunk_nxt = merged;
              out_bytes_nxt = item_r.cnt;
              out_last_nxt  = item_r.last;
              if (item_r.last) begin
                rdy_nxt = 1'b0;
                pos_nxt = '0;
              end
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_SEND;
            end
          end
        end
      end
      S_GEN: begin
        if (core_done) begin
          ks_nxt    = core_block;
          pos_nxt   = '0;
          rdy_nxt   = 1'b1;
          ctr_nxt   = ctr_r + 64'd1;
          state_nxt = S_MIX;
        end
      end
      S_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_chunk_nxt = res_r;
          out_bytes_nxt = item_r.cnt;
          out_last_nxt  = item_r.last;
          if (item_r.last) begin
            rdy_nxt = 1'b0;
            pos_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_ch.valid) begin
      cfg_nxt[cfg_ch.wr_index] = cfg_ch.wr_data;
      if (cfg_ch.wr_index == CFG_COUNTER) begin
        ctr_nxt = cfg_ch.wr_data;
        rdy_nxt = 1'b0;
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= '0;
      ctr_r       <= '0;
      pos_r       <= '0;
      rdy_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      ctr_r       <= ctr_nxt;
      pos_r       <= pos_nxt;
      rdy_r       <= rdy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ks_r        <= ks_nxt;
    item_r      <= item_nxt;
    done_r      <= done_nxt;
    res_r       <= res_nxt;
    out_chunk_r <= out_chunk_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= BLOCK_BYTES) else $error("keystream position past block end");

  a_done_only_gen: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> state_r == S_GEN) else $error("block finished outside generate");

  a_done_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MIX |-> done_r <= item_r.cnt) else $error("more bytes done than requested");

  a_send_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEND |-> out_valid_r) else $error("waiting to send with output free");

endmodule

>>> hdl/chacha20_stream_cipher_core.sv
`timescale 1ns / 1ps
// ChaCha20 stream cipher with a 64-bit block counter. Write the eight 64-bit state
// registers first (index 6 also reloads the running counter), then send message chunks
// of 1 to 8 bytes; each returns one result chunk with the same byte count and last flag,
// invalid bytes zero. A chunk flagged last drops the rest of the current block. While
// keystream is on hand, a chunk is pulled from the input queue in the idle state, then
// merged in the mix state, which registers the result once the output is free. Each
// new 64-byte block comes from the round unit, which does one double round per cycle.
module chacha20_stream_cipher_core import cc20_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cc20_in_if.sink     in_ch,
  cc20_out_if.source  out_ch,
  cc20_cfg_if.sink    cfg_ch
);

  logic   head_valid, head_pop;
  chunk_t head;
  logic   core_start, core_done;
  blk_t   core_init, core_block;

  cc20_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  cc20_core #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (core_start),
    .init  (core_init),
    .done  (core_done),
    .block (core_block)
  );

  cc20_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .core_start (core_start),
    .core_init  (core_init),
    .core_done  (core_done),
    .core_block (core_block),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch)
  );

endmodule
